// ----- rtl/kmnd_pkg.sv -----
`default_nettype none

package kmnd_pkg;

    // Fixed field widths of the matrix reading and the note event.
    localparam int KB_W    = 2;
    localparam int LINE_W  = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 8;

    typedef logic [KB_W-1:0]      t_kb;
    typedef logic [LINE_W-1:0]    t_line;
    typedef logic [NOTE_W-1:0]    t_note;
    typedef logic [VEL_W-1:0]     t_vel;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Default sizing of the key store.
    localparam int DEF_KEYBOARDS  = 3;
    localparam int DEF_NOTE_LIMIT = 70;
    localparam int DEF_LINES      = 15;

    // Only three keyboards carry an offset register.
    localparam int OFFSET_REGS = 3;

    // Wide enough for keyboard * note limit + note at any legal sizing.
    localparam int CALC_W = 10;

    localparam t_byte SENSE_STRIDE  = 8'd6;
    localparam t_vel  VEL_ON        = 7'd127;
    localparam t_vel  VEL_OFF       = 7'd0;
    localparam t_byte DEBOUNCE_RST  = 8'd10;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_PEDAL_OFFSET = 8'd0;
    localparam t_cfg_idx CFG_GREAT_OFFSET = 8'd1;
    localparam t_cfg_idx CFG_SWELL_OFFSET = 8'd2;
    localparam t_cfg_idx CFG_DEBOUNCE     = 8'd3;

endpackage

`default_nettype wire

// ----- rtl/kmnd_ram.sv -----
`default_nettype none

module kmnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/key_matrix_note_debouncer_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    keyboard, drive_line, sense_line, pressed
// out       output     o_out_valid / i_out_ready  event_keyboard, note_number, is_note_on,
//                                                 velocity
// cfg       input      i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// One reading is taken every cycle while o_in_ready is high; it passes the lookup stage,
// which reads the hold counter, then the update stage, which updates and writes it
// back, forwarding between back-to-back readings of one key, then the output register.
// Reset clears the offsets, loads the debounce count and clears a valid bit per key,
// so the store reads as zero at once and no clearing pass is needed.
// o_in_ready drops only while an event waits in the update stage and the output
// register is full and not being taken.
module key_matrix_note_debouncer_unit #(
    parameter int KEYBOARDS  = kmnd_pkg::DEF_KEYBOARDS,
    parameter int NOTE_LIMIT = kmnd_pkg::DEF_NOTE_LIMIT,
    parameter int LINES      = kmnd_pkg::DEF_LINES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire kmnd_pkg::t_kb      i_keyboard,
    input  wire kmnd_pkg::t_line    i_drive_line,
    input  wire kmnd_pkg::t_line    i_sense_line,
    input  wire logic               i_pressed,

    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kmnd_pkg::t_kb           o_event_keyboard,
    output kmnd_pkg::t_note         o_note_number,
    output logic                    o_is_note_on,
    output kmnd_pkg::t_vel          o_velocity,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire kmnd_pkg::t_cfg_idx i_cfg_index,
    input  wire kmnd_pkg::t_byte    i_cfg_data
);

    import kmnd_pkg::*;

    localparam int KB_USED = (KEYBOARDS < OFFSET_REGS) ? KEYBOARDS : OFFSET_REGS;
    localparam int DEPTH   = KB_USED * NOTE_LIMIT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers.
    t_byte r_offset [OFFSET_REGS];
    t_byte r_debounce;

    // Lookup stage.
    logic          r_s1_valid;
    t_kb           r_s1_kb;
    t_note         r_s1_note;
    logic          r_s1_pressed;
    logic [AW-1:0] r_s1_addr;

    // Update stage.
    logic          r_s2_valid;
    t_kb           r_s2_kb;
    t_note         r_s2_note;
    logic          r_s2_pressed;
    logic [AW-1:0] r_s2_addr;

    // Last write, for a reading that looked up the same key before the write reached the store.
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_byte         r_fwd_data;

    // Key valid bits: a clear bit reads as a zero counter.
    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;

    // Output register.
    logic  r_out_valid;
    logic  n_out_valid;
    t_kb   r_out_kb;
    t_note r_out_note;
    logic  r_out_on;

    logic              stall;
    t_byte             offset_sel;
    t_byte             note_sum;
    logic              in_range;
    logic [CALC_W-1:0] addr_calc;
    t_byte             ram_rdata;
    t_byte             count;
    t_byte             new_count;
    logic              emit;
    logic              ram_we;
    logic              load_out;

    // Configuration writes are always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < OFFSET_REGS; i++) begin
                r_offset[i] <= '0;
            end
            r_debounce <= DEBOUNCE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PEDAL_OFFSET: r_offset[0] <= i_cfg_data;
                CFG_GREAT_OFFSET: r_offset[1] <= i_cfg_data;
                CFG_SWELL_OFFSET: r_offset[2] <= i_cfg_data;
                CFG_DEBOUNCE:     r_debounce  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Note number and range checks of the incoming reading.
    always_comb begin
        case (i_keyboard)
            2'd0:    offset_sel = r_offset[0];
            2'd1:    offset_sel = r_offset[1];
            2'd2:    offset_sel = r_offset[2];
            default: offset_sel = '0;
        endcase
        note_sum = offset_sel + BYTE_W'(i_drive_line)
                 + BYTE_W'(SENSE_STRIDE * BYTE_W'(i_sense_line));
        in_range = (32'(i_keyboard) < KB_USED) && (32'(i_drive_line) < LINES)
                 && (32'(i_sense_line) < LINES) && (32'(note_sum) < NOTE_LIMIT);
        addr_calc = CALC_W'(CALC_W'(i_keyboard) * CALC_W'(NOTE_LIMIT))
                  + CALC_W'(note_sum);
    end

    assign o_in_ready = !stall;

    // Lookup stage registers; out-of-range readings are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!stall) begin
            r_s1_valid <= i_in_valid && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1_kb      <= i_keyboard;
            r_s1_note    <= note_sum[NOTE_W-1:0];
            r_s1_pressed <= i_pressed;
            r_s1_addr    <= addr_calc[AW-1:0];
        end
    end

    // Hold counter store.
    kmnd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_counters (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_addr),
        .i_wdata (new_count),
        .i_re    (!stall),
        .i_raddr (r_s1_addr),
        .o_rdata (ram_rdata)
    );

    // Counter update: forward the previous write, and treat unwritten keys as zero.
    always_comb begin
        if (!r_valid[r_s2_addr]) begin
            count = '0;
        end else if (r_fwd_valid && (r_fwd_addr == r_s2_addr)) begin
            count = r_fwd_data;
        end else begin
            count = ram_rdata;
        end

        emit      = 1'b0;
        new_count = count;
        if (r_s2_pressed) begin
            if (count == '0) begin
                emit      = 1'b1;
                new_count = r_debounce;
            end
        end else if (count != '0) begin
            emit      = (count == BYTE_W'(1));
            new_count = count - BYTE_W'(1);
        end

        stall    = r_s2_valid && emit && r_out_valid && !i_out_ready;
        ram_we   = r_s2_valid && !stall;
        load_out = ram_we && emit;

        n_valid = r_valid;
        if (ram_we) begin
            n_valid[r_s2_addr] = 1'b1;
        end

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Update stage and forwarding control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!stall) begin
                r_s2_valid  <= r_s1_valid;
                r_fwd_valid <= ram_we;
            end
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s2_kb      <= r_s1_kb;
            r_s2_note    <= r_s1_note;
            r_s2_pressed <= r_s1_pressed;
            r_s2_addr    <= r_s1_addr;
            r_fwd_addr   <= r_s2_addr;
            r_fwd_data   <= new_count;
        end
        if (load_out) begin
            r_out_kb   <= r_s2_kb;
            r_out_note <= r_s2_note;
            r_out_on   <= r_s2_pressed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_keyboard = r_out_kb;
    assign o_note_number    = r_out_note;
    assign o_is_note_on     = r_out_on;
    assign o_velocity       = r_out_on ? VEL_ON : VEL_OFF;

    // A stalled update stage must not touch the store.
    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |-> !ram_we)
        else $error("counter written while the update stage is stalled");

    // The output register is only loaded when it is free or being emptied.
    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || i_out_ready))
        else $error("note event overwrote a pending transaction");

    // A note-on always arms the counter with the debounce count.
    a_note_on_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_s2_pressed) |-> (new_count == r_debounce))
        else $error("note-on did not load the debounce count");

    // Every forwarded write has marked its key as written.
    a_fwd_key_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> r_valid[r_fwd_addr])
        else $error("forwarded key is not marked valid");

endmodule

`default_nettype wire

// ----- verif/key_matrix_note_debouncer_unit_tb.sv -----
`default_nettype none

module key_matrix_note_debouncer_unit_tb;
    import kmnd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LONG_HOLD      = 100;
    localparam int PHASES         = 8;
    localparam int PRESSURE_PHASE = 4;
    localparam int PHASE_READINGS = 170;
    localparam int DIR_ROWS       = 29;

    // An index that maps to no register; its low bits alias the swell offset.
    localparam t_cfg_idx CFG_NO_REG = 8'd6;

    typedef struct packed {
        t_kb   kb;
        t_note note;
        logic  on;
        t_vel  vel;
    } note_event_t;

    typedef enum logic {ROW_READ, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_EVENT} check_e;

    typedef struct packed {
        row_kind_e   kind;
        t_kb         kb;
        t_line       drive;
        t_line       sense;
        logic        pressed;
        t_cfg_idx    reg_idx;
        t_byte       reg_data;
        check_e      chk;
        note_event_t ev;
    } stim_row_t;

    // Block ports.
    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_kb      i_keyboard = '0;
    t_line    i_drive_line = '0;
    t_line    i_sense_line = '0;
    logic     i_pressed = 1'b0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_kb      o_event_keyboard;
    t_note    o_note_number;
    logic     o_is_note_on;
    t_vel     o_velocity;
    logic     i_cfg_valid = 1'b0;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index = '0;
    t_byte    i_cfg_data = '0;

    // Mirror of the key store and the registers.
    t_byte hold_count [0:DEF_KEYBOARDS-1][0:DEF_NOTE_LIMIT-1];
    t_byte key_offset [0:OFFSET_REGS-1];
    t_byte debounce_load;

    note_event_t expected_events [$];
    stim_row_t   dir_rows [0:DIR_ROWS-1];

    int          fail_count = 0;
    int          readings_counted = 0;
    int unsigned cycle_count = 0;
    logic        send_gaps = 1'b1;
    logic        rx_calm = 1'b0;
    logic        pressure_on = 1'b0;
    int unsigned stall_left = 0;
    int unsigned long_hold_left = 0;
    logic        long_hold_done = 1'b0;

    key_matrix_note_debouncer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_keyboard       (i_keyboard),
        .i_drive_line     (i_drive_line),
        .i_sense_line     (i_sense_line),
        .i_pressed        (i_pressed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_event_keyboard (o_event_keyboard),
        .o_note_number    (o_note_number),
        .o_is_note_on     (o_is_note_on),
        .o_velocity       (o_velocity),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Turns one reading into its note event, if any, and updates the key store.
    function automatic logic debounce_key(input t_kb kb, input t_line drive,
                                          input t_line sense, input logic pressed,
                                          output note_event_t ev);
        t_byte note_sum;
        logic  has_ev;
        has_ev = 1'b0;
        ev = '0;
        if (kb < OFFSET_REGS && kb < DEF_KEYBOARDS && drive < DEF_LINES &&
                sense < DEF_LINES) begin
            note_sum = key_offset[kb] + t_byte'(drive) + t_byte'(sense) * SENSE_STRIDE;
            if (note_sum < DEF_NOTE_LIMIT) begin
                ev.kb = kb;
                ev.note = t_note'(note_sum);
                if (pressed) begin
                    if (hold_count[kb][note_sum] == 8'd0) begin
                        hold_count[kb][note_sum] = debounce_load;
                        ev.on = 1'b1;
                        ev.vel = VEL_ON;
                        has_ev = 1'b1;
                    end
                end else if (hold_count[kb][note_sum] == 8'd1) begin
                    hold_count[kb][note_sum] = 8'd0;
                    ev.on = 1'b0;
                    ev.vel = VEL_OFF;
                    has_ev = 1'b1;
                end else if (hold_count[kb][note_sum] != 8'd0) begin
                    hold_count[kb][note_sum] = hold_count[kb][note_sum] - 8'd1;
                end
            end
        end
        return has_ev;
    endfunction

    // Offers one reading and waits for its transaction; the expected event is queued
    // at the accepting edge. A typed expectation replaces the predicted one.
    task automatic send_reading(input t_kb kb, input t_line drive, input t_line sense,
                                input logic pressed, input check_e chk,
                                input note_event_t typed);
        note_event_t ev;
        logic        has_ev;
        i_in_valid <= 1'b1;
        i_keyboard <= kb;
        i_drive_line <= drive;
        i_sense_line <= sense;
        i_pressed <= pressed;
        do @(posedge i_clk); while (!o_in_ready);
        has_ev = debounce_key(kb, drive, sense, pressed, ev);
        readings_counted++;
        if (chk == CHK_EVENT)
            expected_events.push_back(typed);
        else if (chk == CHK_MODEL && has_ev)
            expected_events.push_back(ev);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Writes one register; valid stays up across back-to-back writes.
    task automatic write_reg(input t_cfg_idx idx, input t_byte data, input logic last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last)
            i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PEDAL_OFFSET: key_offset[0] = data;
            CFG_GREAT_OFFSET: key_offset[1] = data;
            CFG_SWELL_OFFSET: key_offset[2] = data;
            CFG_DEBOUNCE:     debounce_load = data;
            default: ;
        endcase
    endtask

    // Waits until every expected event has come out and the pipeline has drained.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Event receiver: random stalls, one long hold-off under pressure, none when calm.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end else if (long_hold_left != 0) begin
            i_out_ready <= 1'b0;
            long_hold_left <= long_hold_left - 1;
        end else if (pressure_on && !long_hold_done) begin
            i_out_ready <= 1'b0;
            long_hold_left <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
        end else if (rx_calm) begin
            i_out_ready <= 1'b1;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compares each event transaction with the oldest expectation.
    always @(posedge i_clk) begin : event_check
        note_event_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected note event: keyboard %0d note %0d on %0d velocity %0d",
                       o_event_keyboard, o_note_number, o_is_note_on, o_velocity);
                fail_count++;
            end else begin
                want = expected_events.pop_front();
                if (o_event_keyboard !== want.kb) begin
                    $error("event_keyboard: expected %0d, actual %0d", want.kb,
                           o_event_keyboard);
                    fail_count++;
                end
                if (o_note_number !== want.note) begin
                    $error("note_number: expected %0d, actual %0d", want.note, o_note_number);
                    fail_count++;
                end
                if (o_is_note_on !== want.on) begin
                    $error("is_note_on: expected %0d, actual %0d", want.on, o_is_note_on);
                    fail_count++;
                end
                if (o_velocity !== want.vel) begin
                    $error("velocity: expected %0d, actual %0d", want.vel, o_velocity);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int      r;
        int      phase;
        int      presses;
        int      releases;
        int      target;
        t_kb     kb;
        t_line   drive;
        t_line   sense;
        t_byte   offs [0:2];
        t_byte   db;

        dir_rows = '{
            '{ROW_READ, 2'd0, 4'd0,  4'd0,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd0, 7'd0, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd0, 4'd0,  4'd0,  1'b1, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_READ, 2'd2, 4'd14, 4'd9,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd2, 7'd68, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd1, 4'd3,  4'd11, 1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd1, 7'd69, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd1, 4'd4,  4'd11, 1'b1, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_READ, 2'd1, 4'd14, 4'd14, 1'b1, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_READ, 2'd3, 4'd0,  4'd0,  1'b1, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_READ, 2'd0, 4'd15, 4'd0,  1'b1, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_READ, 2'd0, 4'd0,  4'd15, 1'b0, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_READ, 2'd0, 4'd0,  4'd0,  1'b0, 8'd0, 8'd0, CHK_MODEL, '0},
            '{ROW_CFG,  2'd0, 4'd0,  4'd0,  1'b0, CFG_DEBOUNCE, 8'd1, CHK_NONE, '0},
            '{ROW_READ, 2'd0, 4'd5,  4'd1,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd0, 7'd11, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd0, 4'd5,  4'd1,  1'b0, 8'd0, 8'd0, CHK_EVENT,
              '{2'd0, 7'd11, 1'b0, VEL_OFF}},
            '{ROW_READ, 2'd0, 4'd5,  4'd1,  1'b0, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_CFG,  2'd0, 4'd0,  4'd0,  1'b0, CFG_DEBOUNCE, 8'd0, CHK_NONE, '0},
            '{ROW_READ, 2'd1, 4'd0,  4'd0,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd1, 7'd0, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd1, 4'd0,  4'd0,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd1, 7'd0, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd1, 4'd0,  4'd0,  1'b0, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_CFG,  2'd0, 4'd0,  4'd0,  1'b0, CFG_PEDAL_OFFSET, 8'd255, CHK_NONE, '0},
            '{ROW_READ, 2'd0, 4'd2,  4'd0,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd0, 7'd1, 1'b1, VEL_ON}},
            '{ROW_CFG,  2'd0, 4'd0,  4'd0,  1'b0, CFG_GREAT_OFFSET, 8'd255, CHK_NONE, '0},
            '{ROW_READ, 2'd1, 4'd0,  4'd0,  1'b1, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_CFG,  2'd0, 4'd0,  4'd0,  1'b0, CFG_SWELL_OFFSET, 8'd60, CHK_NONE, '0},
            '{ROW_READ, 2'd2, 4'd9,  4'd0,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd2, 7'd69, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd2, 4'd10, 4'd0,  1'b1, 8'd0, 8'd0, CHK_NONE, '0},
            '{ROW_CFG,  2'd0, 4'd0,  4'd0,  1'b0, CFG_DEBOUNCE, 8'd255, CHK_NONE, '0},
            '{ROW_CFG,  2'd0, 4'd0,  4'd0,  1'b0, CFG_NO_REG, 8'h55, CHK_NONE, '0},
            '{ROW_READ, 2'd2, 4'd0,  4'd1,  1'b1, 8'd0, 8'd0, CHK_EVENT,
              '{2'd2, 7'd66, 1'b1, VEL_ON}},
            '{ROW_READ, 2'd2, 4'd0,  4'd1,  1'b0, 8'd0, 8'd0, CHK_MODEL, '0}
        };

        // Reset values of the mirror.
        foreach (hold_count[k, n])
            hold_count[k][n] = 8'd0;
        foreach (key_offset[k])
            key_offset[k] = 8'd0;
        debounce_load = DEBOUNCE_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: extremes, ignored readings, note wrap, zero debounce count.
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                if (r == 0 || dir_rows[r-1].kind != ROW_CFG)
                    settle_block();
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data,
                          r + 1 == DIR_ROWS || dir_rows[r+1].kind != ROW_CFG);
            end else begin
                send_reading(dir_rows[r].kb, dir_rows[r].drive, dir_rows[r].sense,
                             dir_rows[r].pressed, dir_rows[r].chk, dir_rows[r].ev);
            end
        end

        // Random phases, each under its own register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            settle_block();
            case (phase)
                0: begin
                    offs = '{8'd0, 8'd0, 8'd0};
                    db = 8'd1;
                end
                1: begin
                    foreach (offs[k]) offs[k] = t_byte'($urandom_range(0, 20));
                    db = t_byte'($urandom_range(1, 4));
                end
                2: begin
                    offs = '{8'd255, 8'd200, 8'd0};
                    db = 8'd2;
                end
                3: begin
                    foreach (offs[k]) offs[k] = t_byte'($urandom_range(0, 30));
                    db = 8'd0;
                end
                4: begin
                    foreach (offs[k]) offs[k] = t_byte'($urandom_range(0, 15));
                    db = t_byte'($urandom_range(1, 3));
                end
                5: begin
                    foreach (offs[k]) offs[k] = t_byte'($urandom_range(0, 10));
                    db = 8'd255;
                end
                6: begin
                    foreach (offs[k]) offs[k] = t_byte'($urandom_range(0, 255));
                    db = t_byte'($urandom_range(1, 8));
                end
                default: begin
                    foreach (offs[k]) offs[k] = t_byte'($urandom_range(0, 20));
                    db = t_byte'($urandom_range(1, 3));
                end
            endcase
            write_reg(CFG_PEDAL_OFFSET, offs[0], 1'b0);
            write_reg(CFG_GREAT_OFFSET, offs[1], 1'b0);
            write_reg(CFG_SWELL_OFFSET, offs[2], 1'b0);
            write_reg(t_cfg_idx'($urandom_range(4, 255)), t_byte'($urandom()), 1'b0);
            write_reg(CFG_DEBOUNCE, db, 1'b1);

            // The pressure phase and the last phase send back to back.
            send_gaps = !(phase == PRESSURE_PHASE || phase == PHASES - 1);
            if (phase == PRESSURE_PHASE)
                pressure_on <= 1'b1;
            if (phase == PHASES - 1)
                rx_calm <= 1'b1;

            target = readings_counted + PHASE_READINGS;
            while (readings_counted < target) begin
                if ($urandom_range(0, 3) == 0) begin
                    // Noise: any field value, out-of-range ones included.
                    send_reading(t_kb'($urandom_range(0, 3)), t_line'($urandom_range(0, 15)),
                                 t_line'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                                 CHK_MODEL, '0);
                end else begin
                    // One key: a bouncing press, then enough releases to send note-off,
                    // sometimes cut short.
                    kb = t_kb'($urandom_range(0, 2));
                    drive = t_line'($urandom_range(0, 14));
                    if ($urandom_range(0, 4) == 0)
                        sense = t_line'($urandom_range(0, 14));
                    else
                        sense = t_line'($urandom_range(0, 10));
                    presses = $urandom_range(1, 3);
                    releases = int'(debounce_load) + $urandom_range(0, 2);
                    if ($urandom_range(0, 3) == 0)
                        releases = $urandom_range(0, releases);
                    repeat (presses)
                        send_reading(kb, drive, sense, 1'b1, CHK_MODEL, '0);
                    repeat (releases) begin
                        if ($urandom_range(0, 9) == 0)
                            send_reading(kb, drive, sense, 1'b1, CHK_MODEL, '0);
                        send_reading(kb, drive, sense, 1'b0, CHK_MODEL, '0);
                    end
                end
            end
        end

        settle_block();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/kmnd_pkg.sv
rtl/kmnd_ram.sv
rtl/key_matrix_note_debouncer_unit.sv
verif/key_matrix_note_debouncer_unit_tb.sv
